// File: sv/cds_pkg.sv
// Shared types and constants for the clock divider search unit.
package cds_pkg;

  // Source rate after optional doubling, and candidate error width.
  localparam int RATE_W = 33;
  localparam int ERR_W  = 33;

  // Status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_IN_USE = 2'd2;
  localparam logic [1:0] ST_ABOVE  = 2'd3;

  typedef struct packed {
    logic [31:0] source_hz;
    logic [31:0] target_hz;
    logic        clock_present;
    logic        clock_in_use;
  } req_t;

  typedef struct packed {
    logic [2:0]  divider_code;
    logic        fraction_bit;
    logic [31:0] rate_error;
    logic [2:0]  division_remainder;
    logic [1:0]  status;
  } rsp_t;

endpackage

// File: sv/clock_divider_search_unit.sv
// Top level of the clock divider search unit: input stage, lanes, min tree, output skid.
//
// Fully pipelined search: one transaction is taken every clock cycle while
// req_stall is low. Each request passes the input register, the five-stage
// lanes (reciprocal multiply split in two partial products, quotient,
// remainder, correction, absolute error) and one registered level per halving
// of the 2*DIV_STEPS candidates in the minimum tree. Every divider code is
// evaluated in its own lane, with and without the doubled source rate; the
// tree keeps the candidate with the least error, then the least remainder,
// the earliest one winning a full tie. A two-entry output (pipeline end plus
// skid register) lets the pipeline keep moving when rsp_stall rises, the skid
// catching the result at the pipeline end; req_stall is high only while the
// skid holds a transaction. An absent clock or one in use returns zeros with
// its status; a target above the source is flagged and still searched.
module clock_divider_search_unit import cds_pkg::*; #(
  parameter int DIV_STEPS = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int NC       = 2 * DIV_STEPS;             // candidates
  localparam int PW       = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
  localparam int REM_W    = PW;                        // remainder < DIV_STEPS
  localparam int LANE_LAT = 5;
  localparam int TREE_LAT = $clog2(NC);
  localparam int NS       = 1 + LANE_LAT + TREE_LAT;   // sideband stages

  // per-transaction control that rides alongside the lanes
  typedef struct packed {
    logic        v;
    logic [31:0] tgt;
    logic        skip;     // doubled rate below target: no fractional pass
    logic        zero;     // absent or in use: result fields forced to zero
    logic [1:0]  status;
  } side_t;

  side_t       sb [NS];
  logic [31:0] src;
  logic        adv;
  logic        accept;

  logic [RATE_W-1:0] rate_plain, rate_dbl;

  logic             leaf_v   [NC];
  logic [ERR_W-1:0] leaf_err [NC];
  logic [REM_W-1:0] leaf_rem [NC];
  logic [PW-1:0]    leaf_pcd [NC];
  logic             leaf_frac[NC];

  logic             best_v;
  logic [ERR_W-1:0] best_err;
  logic [REM_W-1:0] best_rem;
  logic [PW-1:0]    best_pcd;
  logic             best_frac;

  rsp_t pipe_rsp;
  rsp_t skid;
  logic skid_v;
  side_t sb_in;

  // whole pipeline moves unless the skid is occupied
  assign adv       = !skid_v;
  assign req_stall = skid_v;
  assign accept    = req_valid && !req_stall;

  always_comb begin
    sb_in.v    = accept;
    sb_in.tgt  = req.target_hz;
    sb_in.skip = {1'b0, req.target_hz} > {req.source_hz, 1'b0};
    sb_in.zero = !req.clock_present || req.clock_in_use;
    if (!req.clock_present) begin
      sb_in.status = ST_ABSENT;
    end else if (req.clock_in_use) begin
      sb_in.status = ST_IN_USE;
    end else if (req.target_hz > req.source_hz) begin
      sb_in.status = ST_ABOVE;
    end else begin
      sb_in.status = ST_OK;
    end
  end

  // sideband shift line; only valid bits are reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NS; i++) begin
        sb[i].v <= 1'b0;
      end
    end else if (adv) begin
      sb[0] <= sb_in;
      for (int i = 1; i < NS; i++) begin
        sb[i] <= sb[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      src <= req.source_hz;
    end
  end

  assign rate_plain = {1'b0, src};
  assign rate_dbl   = {src, 1'b0};

  // candidate k: fraction bit k / DIV_STEPS, divider code k % DIV_STEPS
  for (genvar k = 0; k < NC; k++) begin : g_lane
    localparam int FRAC = k / DIV_STEPS;
    localparam int PCD  = k % DIV_STEPS;

    cds_lane #(
      .DIVISOR (PCD + 1),
      .REM_W   (REM_W)
    ) u_lane (
      .clk  (clk),
      .en   (adv),
      .rate ((FRAC != 0) ? rate_dbl : rate_plain),
      .tgt  (sb[LANE_LAT-1].tgt),
      .err  (leaf_err[k]),
      .rem  (leaf_rem[k])
    );

    assign leaf_v[k]    = (FRAC == 0) || !sb[LANE_LAT].skip;
    assign leaf_pcd[k]  = PW'(PCD);
    assign leaf_frac[k] = (FRAC != 0);
  end

  cds_min_tree #(
    .N     (NC),
    .PW    (PW),
    .REM_W (REM_W)
  ) u_tree (
    .clk       (clk),
    .en        (adv),
    .leaf_v    (leaf_v),
    .leaf_err  (leaf_err),
    .leaf_rem  (leaf_rem),
    .leaf_pcd  (leaf_pcd),
    .leaf_frac (leaf_frac),
    .best_v    (best_v),
    .best_err  (best_err),
    .best_rem  (best_rem),
    .best_pcd  (best_pcd),
    .best_frac (best_frac)
  );

  always_comb begin
    pipe_rsp.status = sb[NS-1].status;
    if (sb[NS-1].zero) begin
      pipe_rsp.divider_code       = '0;
      pipe_rsp.fraction_bit       = 1'b0;
      pipe_rsp.rate_error         = '0;
      pipe_rsp.division_remainder = '0;
    end else begin
      pipe_rsp.divider_code       = 3'(best_pcd);
      pipe_rsp.fraction_bit       = best_frac;
      pipe_rsp.rate_error         = best_err[31:0];
      pipe_rsp.division_remainder = 3'(best_rem);
    end
  end

  // skid register catches the pipeline end when the consumer stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (!rsp_stall) begin
        skid_v <= 1'b0;
      end
    end else if (sb[NS-1].v && rsp_stall) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_v) begin
      skid <= pipe_rsp;
    end
  end

  assign rsp_valid = skid_v || sb[NS-1].v;
  assign rsp       = skid_v ? skid : pipe_rsp;

  // the plain pcd 0 candidate is always live, so the tree never comes up empty
  a_root_live: assert property (@(posedge clk) disable iff (rst)
    sb[NS-1].v |-> best_v)
    else $error("min tree returned no candidate");

  // winning error is bounded by |source - target|, hence fits 32 bits
  a_err_fits: assert property (@(posedge clk) disable iff (rst)
    (sb[NS-1].v && !sb[NS-1].zero) |-> !best_err[ERR_W-1])
    else $error("winning error exceeds 32 bits");

  // rejected requests report zeros
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.status == ST_ABSENT || rsp.status == ST_IN_USE)) |->
    (rsp.rate_error == '0 && rsp.divider_code == '0 &&
     rsp.fraction_bit == 1'b0 && rsp.division_remainder == '0))
    else $error("nonzero fields on absent or in-use clock");

  // a held skid entry leaves only when the consumer takes it
  a_skid_hold: assert property (@(posedge clk) disable iff (rst)
    (skid_v && rsp_stall) |=> (skid_v && $stable(skid)))
    else $error("skid entry dropped while stalled");

  // while the skid is full the pipeline end is frozen
  a_pipe_frozen: assert property (@(posedge clk) disable iff (rst)
    skid_v |=> $stable(sb[NS-1].v))
    else $error("pipeline advanced while skid full");

endmodule

// File: sv/cds_lane.sv
// One candidate lane: divide by a fixed divisor, then absolute error to target.
module cds_lane import cds_pkg::*; #(
  parameter int DIVISOR = 1,
  parameter int REM_W   = 3
) (
  input  logic              clk,
  input  logic              en,
  input  logic [RATE_W-1:0] rate,
  input  logic [31:0]       tgt,
  output logic [ERR_W-1:0]  err,
  output logic [REM_W-1:0]  rem
);

  // floor(2^33 / d): quotient estimate is exact or one low
  localparam logic [33:0] RECIP = 34'((64'd1 << 33) / 64'(DIVISOR));
  localparam logic [6:0]  DIV_K = 7'(DIVISOR);

  logic [RATE_W-1:0] rate1, rate2;
  logic [49:0]       prod_lo, prod_hi;
  logic [RATE_W-1:0] q0, q0_3, q4;
  logic [7:0]        r0;
  logic [REM_W-1:0]  r4;

  logic [66:0]       full;
  logic [39:0]       back;
  logic [7:0]        r0_next;

  assign full    = {prod_hi, 17'd0} + {17'd0, prod_lo};
  assign back    = {7'd0, q0} * {33'd0, DIV_K};
  // true remainder is below 2*d, so the low byte is enough
  assign r0_next = rate2[7:0] - back[7:0];

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: partial products of rate * reciprocal
      rate1   <= rate;
      prod_lo <= {17'd0, rate} * {33'd0, RECIP[16:0]};
      prod_hi <= {17'd0, rate} * {33'd0, RECIP[33:17]};
      // stage 2: quotient estimate
      rate2   <= rate1;
      q0      <= full[65:33];
      // stage 3: remainder of the estimate
      q0_3    <= q0;
      r0      <= r0_next;
      // stage 4: single correction step
      if (r0 >= {1'b0, DIV_K}) begin
        q4 <= q0_3 + RATE_W'(1);
        r4 <= REM_W'(r0 - {1'b0, DIV_K});
      end else begin
        q4 <= q0_3;
        r4 <= REM_W'(r0);
      end
      // stage 5: absolute error
      if (q4 > {1'b0, tgt}) begin
        err <= q4 - {1'b0, tgt};
      end else begin
        err <= {1'b0, tgt} - q4;
      end
      rem <= r4;
    end
  end

endmodule

// File: sv/cds_min_tree.sv
// Registered tree picking the first candidate with least (error, remainder).
module cds_min_tree import cds_pkg::*; #(
  parameter int N     = 16,
  parameter int PW    = 3,
  parameter int REM_W = 3
) (
  input  logic             clk,
  input  logic             en,
  input  logic             leaf_v   [N],
  input  logic [ERR_W-1:0] leaf_err [N],
  input  logic [REM_W-1:0] leaf_rem [N],
  input  logic [PW-1:0]    leaf_pcd [N],
  input  logic             leaf_frac[N],
  output logic             best_v,
  output logic [ERR_W-1:0] best_err,
  output logic [REM_W-1:0] best_rem,
  output logic [PW-1:0]    best_pcd,
  output logic             best_frac
);

  localparam int LVL = (N > 1) ? $clog2(N) : 1;
  localparam int P   = 1 << LVL;
  localparam int NI  = P - 1;       // registered inner nodes
  localparam int NT  = 2 * P - 1;   // inner nodes plus leaves

  logic             nv [NI];
  logic [ERR_W-1:0] ne [NI];
  logic [REM_W-1:0] nr [NI];
  logic [PW-1:0]    np [NI];
  logic             nf [NI];

  logic             vv [NT];
  logic [ERR_W-1:0] ve [NT];
  logic [REM_W-1:0] vr [NT];
  logic [PW-1:0]    vp [NT];
  logic             vf [NT];

  logic             take_right [NI];

  // heap view: inner registers first, then leaves in candidate order
  always_comb begin
    for (int j = 0; j < NT; j++) begin
      if (j < NI) begin
        vv[j] = nv[j];
        ve[j] = ne[j];
        vr[j] = nr[j];
        vp[j] = np[j];
        vf[j] = nf[j];
      end else if (j - NI < N) begin
        vv[j] = leaf_v[j - NI];
        ve[j] = leaf_err[j - NI];
        vr[j] = leaf_rem[j - NI];
        vp[j] = leaf_pcd[j - NI];
        vf[j] = leaf_frac[j - NI];
      end else begin
        vv[j] = 1'b0;
        ve[j] = '0;
        vr[j] = '0;
        vp[j] = '0;
        vf[j] = 1'b0;
      end
    end
  end

  // right side wins only when strictly better, so the earliest tie survives
  always_comb begin
    for (int i = 0; i < NI; i++) begin
      take_right[i] = vv[2*i+2] &&
                      (!vv[2*i+1] ||
                       (ve[2*i+2] < ve[2*i+1]) ||
                       ((ve[2*i+2] == ve[2*i+1]) && (vr[2*i+2] < vr[2*i+1])));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NI; i++) begin
        if (take_right[i]) begin
          nv[i] <= vv[2*i+2];
          ne[i] <= ve[2*i+2];
          nr[i] <= vr[2*i+2];
          np[i] <= vp[2*i+2];
          nf[i] <= vf[2*i+2];
        end else begin
          nv[i] <= vv[2*i+1];
          ne[i] <= ve[2*i+1];
          nr[i] <= vr[2*i+1];
          np[i] <= vp[2*i+1];
          nf[i] <= vf[2*i+1];
        end
      end
    end
  end

  assign best_v    = nv[0];
  assign best_err  = ne[0];
  assign best_rem  = nr[0];
  assign best_pcd  = np[0];
  assign best_frac = nf[0];

endmodule

// File: verif/cds_search_checker.sv
`timescale 1ns / 100ps
// Checker for the clock divider search unit: predicts each result and compares it.
module cds_search_checker import cds_pkg::*; #(
  parameter int DIV_STEPS = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_stall,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_stall,
  input  rsp_t rsp,
  output int   fail_count,
  output int   pending_results
);

  // Predicted settings, oldest first.
  rsp_t expected_settings[$];
  int   failures = 0;

  function automatic logic [63:0] rate_gap(logic [63:0] a, logic [63:0] b);
    return (a < b) ? b - a : a - b;
  endfunction

  // Best divider setting for one request; rates are carried at 64 bits so the
  // doubled source and wide fractional errors never wrap.
  function automatic rsp_t predict_divider_setting(req_t item);
    logic [63:0] src;
    logic [63:0] tgt;
    logic [63:0] rate;
    logic [63:0] quo;
    logic [63:0] rmd;
    logic [63:0] err;
    logic [63:0] best_err;
    logic [63:0] best_rem;
    int          best_pcd;
    logic        best_frac;
    rsp_t        res;
    res = '0;
    if (!item.clock_present) begin
      res.status = ST_ABSENT;
      return res;
    end
    if (item.clock_in_use) begin
      res.status = ST_IN_USE;
      return res;
    end
    src = {32'd0, item.source_hz};
    tgt = {32'd0, item.target_hz};
    best_err = rate_gap(src, tgt);
    best_rem = '0;
    best_pcd = 0;
    best_frac = 1'b0;
    for (int pass = 0; pass < 2; pass++) begin
      rate = src << pass;
      // fractional pass is skipped when the doubled rate is below the target
      if (pass == 0 || tgt <= rate) begin
        for (int pcd = 0; pcd < DIV_STEPS; pcd++) begin
          quo = rate / 64'(pcd + 1);
          rmd = rate % 64'(pcd + 1);
          err = rate_gap(quo, tgt);
          if (err < best_err || (err == best_err && rmd < best_rem)) begin
            best_err = err;
            best_rem = rmd;
            best_pcd = pcd;
            best_frac = (pass == 1);
          end
        end
      end
    end
    res.divider_code = best_pcd[2:0];
    res.fraction_bit = best_frac;
    res.rate_error = best_err[31:0];
    res.division_remainder = best_rem[2:0];
    res.status = (tgt > src) ? ST_ABOVE : ST_OK;
    return res;
  endfunction

  always @(posedge clk) begin : watch_transactions
    rsp_t want;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_settings.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("%0t: unexpected result: pcd %0d frac %0d err %0d rem %0d st %0d",
                     $time, rsp.divider_code, rsp.fraction_bit, rsp.rate_error,
                     rsp.division_remainder, rsp.status);
        end else begin
          want = expected_settings.pop_front();
          if (want.divider_code !== rsp.divider_code ||
              want.fraction_bit !== rsp.fraction_bit ||
              want.rate_error !== rsp.rate_error ||
              want.division_remainder !== rsp.division_remainder ||
              want.status !== rsp.status) begin
            failures++;
            if (failures <= 10) begin
              $display("%0t: mismatch, expected pcd %0d frac %0d err %0d rem %0d st %0d",
                       $time, want.divider_code, want.fraction_bit, want.rate_error,
                       want.division_remainder, want.status);
              $display("%0t:           actual pcd %0d frac %0d err %0d rem %0d st %0d",
                       $time, rsp.divider_code, rsp.fraction_bit, rsp.rate_error,
                       rsp.division_remainder, rsp.status);
            end
          end
        end
      end
      if (req_valid && !req_stall)
        expected_settings.push_back(predict_divider_setting(req));
    end
    fail_count <= failures;
    pending_results <= expected_settings.size();
  end

endmodule

// File: verif/tb_clock_divider_search_unit.sv
`timescale 1ns / 100ps
// Testbench top for the clock divider search unit: clock, reset, requests and verdict.
module tb_clock_divider_search_unit import cds_pkg::*;;

  localparam int DIV_STEPS       = 8;
  // pipeline depth of the design: input register, lanes and min tree
  localparam int RESULT_LATENCY  = 6 + $clog2(2 * DIV_STEPS);
  localparam int RANDOM_REQUESTS = 400;
  // cycles without any transaction before the run is declared hung
  localparam int HANG_LIMIT      = 2000;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  int   fail_count;
  int   pending_results;
  logic steady_run = 1'b0;  // while set, neither side idles
  int   quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  clock_divider_search_unit #(
    .DIV_STEPS(DIV_STEPS)
  ) u_dut (
    .clk,
    .rst,
    .req_valid,
    .req_stall,
    .req,
    .rsp_valid,
    .rsp_stall,
    .rsp
  );

  cds_search_checker #(
    .DIV_STEPS(DIV_STEPS)
  ) u_checker (
    .clk,
    .rst,
    .req_valid,
    .req_stall,
    .req,
    .rsp_valid,
    .rsp_stall,
    .rsp,
    .fail_count,
    .pending_results
  );

  // Result side: stall about a third of the cycles, except in the steady stretch.
  always @(posedge clk) begin
    rsp_stall <= !steady_run && ($urandom_range(99) < 32);
  end

  // Hang detection: any accepted transaction on either channel restarts the count.
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic req_t make_request(logic [31:0] src, logic [31:0] tgt,
                                        logic present, logic in_use);
    req_t item;
    item.source_hz = src;
    item.target_hz = tgt;
    item.clock_present = present;
    item.clock_in_use = in_use;
    return item;
  endfunction

  // Random request. Most are live clocks with a target near an achievable
  // rate, so the search has close candidates and real tie-breaks to resolve.
  function automatic req_t random_clock_request();
    req_t        item;
    logic [32:0] rate;
    int unsigned mode;
    int unsigned ratio;
    mode = $urandom_range(9);
    item.source_hz = $urandom();
    item.target_hz = $urandom();
    item.clock_present = 1'b1;
    item.clock_in_use = 1'b0;
    case (mode)
      0: begin
        // any flag combination, including absent and in-use clocks
        item.clock_present = 1'($urandom_range(1));
        item.clock_in_use = 1'($urandom_range(1));
      end
      1, 2: ;  // unrelated rates, full range
      7: begin
        // target at or just above the source
        item.target_hz = item.source_hz + $urandom_range(1000);
      end
      8: begin
        // tiny rates: remainders dominate the tie-break
        item.source_hz = $urandom_range(64);
        item.target_hz = $urandom_range(64);
      end
      default: begin
        // plain or doubled source over a ratio, nudged by a few hertz
        ratio = $urandom_range(2 * DIV_STEPS, 1);
        rate = {1'b0, item.source_hz} << $urandom_range(1);
        item.target_hz = 32'(rate / ratio) + $urandom_range(6) - 32'd3;
      end
    endcase
    return item;
  endfunction

  // One request transaction. Idle cycles come first; once valid is raised the
  // payload holds until the stall drops at a clock edge.
  task automatic send_clock_request(input req_t item);
    while (!steady_run && $urandom_range(99) < 32) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  initial begin
    rst <= 1'b1;
    req_valid <= 1'b0;
    req <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: flag priorities, field extremes and the search corner cases.
    send_clock_request(make_request(32'd48_000_000, 32'd12_000_000, 1'b0, 1'b0));
    // absent takes priority over in use
    send_clock_request(make_request(32'd48_000_000, 32'd12_000_000, 1'b0, 1'b1));
    send_clock_request(make_request(32'd48_000_000, 32'd12_000_000, 1'b1, 1'b1));
    send_clock_request(make_request(32'd0, 32'd0, 1'b1, 1'b0));
    // target above source, doubled rate at or below the target
    send_clock_request(make_request(32'd0, 32'd1, 1'b1, 1'b0));
    send_clock_request(make_request(32'd1, 32'd2, 1'b1, 1'b0));
    send_clock_request(make_request(32'd1, 32'd3, 1'b1, 1'b0));
    send_clock_request(make_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0));
    send_clock_request(make_request(32'hFFFF_FFFF, 32'd0, 1'b1, 1'b0));
    send_clock_request(make_request(32'hFFFF_FFFF, 32'd1, 1'b1, 1'b0));
    // doubled source needs all 33 bits
    send_clock_request(make_request(32'hFFFF_FFFF, 32'h8000_0000, 1'b1, 1'b0));
    send_clock_request(make_request(32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0));
    // fractional candidates with errors wider than 32 bits
    send_clock_request(make_request(32'hF000_0000, 32'd0, 1'b1, 1'b0));
    send_clock_request(make_request(32'd100_000_000, 32'd12_000_000, 1'b1, 1'b0));
    // only the doubled source hits this one exactly
    send_clock_request(make_request(32'd48_000_000, 32'd32_000_000, 1'b1, 1'b0));
    // equal errors, smaller remainder must win
    send_clock_request(make_request(32'd7, 32'd3, 1'b1, 1'b0));
    send_clock_request(make_request(32'd10, 32'd3, 1'b1, 1'b0));
    send_clock_request(make_request(32'd24_000_000, 32'd8_000_000, 1'b1, 1'b0));
    send_clock_request(make_request(32'd12_345_678, 32'd87_654_321, 1'b1, 1'b0));
    send_clock_request(make_request(32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 1'b0));
    send_clock_request(make_request(32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 1'b0));

    // Let the pipeline drain completely before the random traffic.
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);

    // Random traffic; a block in the middle runs with no idling on either side.
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      steady_run <= (n >= 150 && n < 250);
      send_clock_request(random_clock_request());
    end
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    // watch a little past the pipeline depth for stray results
    repeat (RESULT_LATENCY + 4) @(posedge clk);

    if (fail_count == 0 && pending_results == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
sv/cds_pkg.sv
sv/cds_lane.sv
sv/cds_min_tree.sv
sv/clock_divider_search_unit.sv
verif/cds_search_checker.sv
verif/tb_clock_divider_search_unit.sv
